// File: design/eqs_pkg.sv
package eqs_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT_IDLE = 2'd0,
    PH_STROBE    = 2'd1,
    PH_WAIT_DONE = 2'd2,
    PH_RETIRE    = 2'd3
  } phase_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] req_address;
    logic [7:0] req_value;
    logic       ee_busy;
  } in_item_t;

  typedef struct packed {
    logic       write_strobe;
    logic [7:0] write_address;
    logic [7:0] write_data;
    logic [3:0] pending;
    logic       dropped;
  } out_item_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: design/eqs_ring_mem.sv
module eqs_ring_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  eqs_pkg::mem_ctl_t        mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  eqs_pkg::entry_t          wr_entry,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output eqs_pkg::entry_t          rd_entry
);
  import eqs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (mem_ctl.rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// File: design/eqs_ctrl.sv
module eqs_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  eqs_pkg::in_item_t        in_data,
  output logic                     in_ready,
  input  logic                     out_free,
  output logic                     res_load,
  output eqs_pkg::out_item_t       res,
  output eqs_pkg::mem_ctl_t        mem_ctl,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output eqs_pkg::entry_t          wr_entry,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  eqs_pkg::entry_t          rd_entry
);
  import eqs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH - 1);

  ctl_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W+3:0] cnt_ext;
  logic             acc;
  logic             is_push;
  logic             full;
  logic             not_empty;

  assign in_ready  = (state_r == CS_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign is_push   = (in_data.command == CMD_PUSH);
  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (acc && !is_push && not_empty && phase_r == PH_STROBE) begin
          state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    mem_ctl         = '0;
    res_load        = 1'b0;
    res             = '0;
    wr_addr         = tail_r;
    wr_entry.addr   = in_data.req_address;
    wr_entry.data   = in_data.req_value;
    rd_addr         = head_r;
    unique case (state_r)
      CS_IDLE: begin
        if (acc) begin
          res_load = 1'b1;
          if (is_push) begin
            if (full) begin
              res.dropped = 1'b1;
            end else begin
              mem_ctl.wr_en = 1'b1;
              tail_nxt      = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
              count_nxt     = count_r + 1'b1;
            end
          end else if (not_empty) begin
            unique case (phase_r)
              PH_WAIT_IDLE: begin
                if (!in_data.ee_busy) begin
                  phase_nxt = PH_STROBE;
                end
              end
              PH_STROBE: begin
                mem_ctl.rd_en = rst_n;
                res_load      = 1'b0;
                phase_nxt     = PH_WAIT_DONE;
              end
              PH_WAIT_DONE: begin
                if (!in_data.ee_busy) begin
                  phase_nxt = PH_RETIRE;
                end
              end
              PH_RETIRE: begin
                head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                phase_nxt = PH_WAIT_IDLE;
              end
              default: phase_nxt = PH_WAIT_IDLE;
            endcase
          end
        end
      end
      CS_READ: begin
        res_load          = 1'b1;
        res.write_strobe  = 1'b1;
        res.write_address = rd_entry.addr;
        res.write_data    = rd_entry.data;
      end
      default: ;
    endcase
    cnt_ext     = {4'b0000, count_nxt};
    res.pending = cnt_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      phase_r <= PH_WAIT_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/eeprom_write_queue_sequencer.sv
// A push or a tick without strobe has its result in the output register in the cycle after it is taken;
// a strobe tick first reads the queue memory into its read register (state CS_READ), then loads the result.
// Throughput: one item per cycle while the output is free; a strobe tick holds the input off in CS_READ.
// Reset (rst_n low, synchronous) clears head, tail, count, phase and the output valid flag;
// queue memory contents stay undefined and need no clearing pass.
module eeprom_write_queue_sequencer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  eqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eqs_pkg::out_item_t out_data
);
  import eqs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             out_free;
  logic             res_load;
  out_item_t        res;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           wr_entry;
  entry_t           rd_entry;

  assign out_free = !out_valid_r || out_ready;

  eqs_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  eqs_ring_mem #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ring_mem (
    .clk      (clk),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_read_then_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(mem_ctl.rd_en) |-> res_load && res.write_strobe)
    else $error("memory read not followed by strobe result");

  a_no_strobe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_strobe |->
      out_data.write_address == 8'h00 && out_data.write_data == 8'h00)
    else $error("write fields non-zero without strobe");

  a_drop_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> !out_data.write_strobe)
    else $error("dropped and strobe in the same item");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over an untaken item");
`endif

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eqs_pkg::*;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_OFF    = 300;

  class write_queue_scoreboard;
    logic [7:0] addr_mem [DEPTH];
    logic [7:0] data_mem [DEPTH];
    int         head_idx;
    int         tail_idx;
    phase_t     seq_phase;
    out_item_t  due_results[$];
    int         errors;

    function new();
      head_idx  = 0;
      tail_idx  = 0;
      seq_phase = PH_WAIT_IDLE;
      errors    = 0;
    endfunction

    function int occupancy();
      return (tail_idx + DEPTH - head_idx) % DEPTH;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      r = '0;
      if (it.command == CMD_PUSH) begin
        if (occupancy() >= DEPTH - 1) begin
          r.dropped = 1'b1;
        end else begin
          addr_mem[tail_idx] = it.req_address;
          data_mem[tail_idx] = it.req_value;
          tail_idx = (tail_idx + 1) % DEPTH;
        end
      end else if (head_idx != tail_idx) begin
        case (seq_phase)
          PH_WAIT_IDLE: if (!it.ee_busy) seq_phase = PH_STROBE;
          PH_STROBE: begin
            r.write_strobe  = 1'b1;
            r.write_address = addr_mem[head_idx];
            r.write_data    = data_mem[head_idx];
            seq_phase       = PH_WAIT_DONE;
          end
          PH_WAIT_DONE: if (!it.ee_busy) seq_phase = PH_RETIRE;
          default: begin
            head_idx  = (head_idx + 1) % DEPTH;
            seq_phase = PH_WAIT_IDLE;
          end
        endcase
      end
      r.pending = 4'(occupancy());
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("write_strobe", 8'(want.write_strobe), 8'(got.write_strobe));
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_data", want.write_data, got.write_data);
      compare_field("pending", 8'(want.pending), 8'(got.pending));
      compare_field("dropped", 8'(want.dropped), 8'(got.dropped));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  write_queue_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_cycles = 0;

  eeprom_write_queue_sequencer #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic cmd, logic [7:0] addr, logic [7:0] val,
                                         logic busy);
    in_item_t it;
    it.command     = cmd;
    it.req_address = addr;
    it.req_value   = val;
    it.ee_busy     = busy;
    return it;
  endfunction

  function automatic in_item_t random_item(int push_pct, int busy_pct);
    return make_item(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_TICK,
                     8'($urandom), 8'($urandom), $urandom_range(99) < busy_pct);
  endfunction

  // enter and leave at a falling edge
  task automatic drive_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(negedge clk);
  endtask

  task automatic run_random(int n_items);
    int sent;
    int push_pct;
    int busy_pct;
    int seg_len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      busy_pct = 35 * $urandom_range(2);
      seg_len  = $urandom_range(20, 60);
      repeat (seg_len) begin
        drive_item(random_item(push_pct, busy_pct));
        sent++;
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("eeprom_write_queue_sequencer verification failed");
    $finish;
  end

  initial begin
    in_item_t directed[$];
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 50, 0, 23};
    stall_set = '{0, 0, 50, 23};
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;

    // ticks on an empty queue, then one entry through every phase
    directed.push_back(make_item(CMD_TICK, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_TICK, 8'hff, 8'hff, 1'b1));
    directed.push_back(make_item(CMD_PUSH, 8'h00, 8'hff, 1'b1));
    directed.push_back(make_item(CMD_PUSH, 8'hff, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_TICK, 8'hff, 8'hff, 1'b1));
    directed.push_back(make_item(CMD_TICK, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_TICK, 8'h5a, 8'ha5, 1'b1));
    directed.push_back(make_item(CMD_TICK, 8'h00, 8'h00, 1'b1));
    directed.push_back(make_item(CMD_TICK, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_TICK, 8'hff, 8'h00, 1'b0));
    // fill to the brim, wrap the tail, then one push too many
    for (int i = 0; i < DEPTH - 1; i++)
      directed.push_back(make_item(CMD_PUSH, 8'(8'hf0 + i), 8'(8'h0f + 16 * i), i[0]));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) drive_item(directed[i]);
    pause_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) hold_cycles = HOLD_OFF;
      run_random(PHASE_ITEMS);
      pause_until_drained();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("eeprom_write_queue_sequencer verification clean");
    end else begin
      $display("eeprom_write_queue_sequencer verification failed");
    end
    $finish;
  end

endmodule
